// ===== rtl/lsd_pkg.sv =====
// package for the radix sorter: payload types, capacity and cell control
package lsd_pkg;

    localparam int LSD_VALUE_W   = 31;
    localparam int LSD_MAX_ITEMS = 64;

    typedef struct packed {
        logic [LSD_VALUE_W-1:0] value;
        logic                   last;
    } lsd_in_t;

    typedef struct packed {
        logic [LSD_VALUE_W-1:0] sorted_value;
        logic                   last_out;
        logic                   dropped;
    } lsd_out_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift_out;
    } lsd_cell_ctrl_t;

endpackage

// ===== rtl/lsd_radix_sorter_core.sv =====
// top level of the sorter: chain of sorting cells, load and drain control
// items load one per cycle while busy is low; after the closing transfer busy stays high until
// the chain has drained, and results, registered from cell zero, follow at one result per cycle
// a new set is not taken until the last one has drained: the single-entry insert into the cell chain
// and the one-value-per-cycle drain out of cell zero do not overlap
// reset clears control state, occupancy and the overflow mark; cell values are not reset
// the receiver cannot stall: each result is shown for exactly one cycle
module lsd_radix_sorter_core
    import lsd_pkg::*;
#(
    parameter int MAX_ITEMS = LSD_MAX_ITEMS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  lsd_in_t  item,
    output logic     busy,
    output logic     result_valid,
    output lsd_out_t result
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic           state_reg;
    logic           state_next;
    logic           overflow_reg;
    logic           overflow_next;
    logic           result_valid_reg;
    logic           result_valid_next;
    lsd_out_t       result_reg;
    lsd_out_t       result_next;

    logic           accept;
    logic           full;
    lsd_cell_ctrl_t ctrl;

    // per-cell views of the chain
    logic [MAX_ITEMS-1:0]   cell_gt;
    logic [MAX_ITEMS-1:0]   cell_occ;
    logic [LSD_VALUE_W-1:0] cell_value [MAX_ITEMS];

    // a transfer is taken whenever the chain is not draining
    assign busy   = (state_reg == ST_DRAIN);
    assign accept = start && !busy;
    // occupancy fills from cell zero up, so the top cell marks a full set
    assign full   = cell_occ[MAX_ITEMS-1];

    assign ctrl.insert    = accept && !full;
    assign ctrl.shift_out = busy;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic                   prev_gt;
            logic [LSD_VALUE_W-1:0] prev_value;
            logic                   prev_occ;
            logic [LSD_VALUE_W-1:0] next_value;
            logic                   next_occ;

            if (gi == 0)
            begin : g_head
                // nothing below cell zero: it always takes the new value when larger
                assign prev_gt    = 1'b0;
                assign prev_value = item.value;
                assign prev_occ   = 1'b1;
            end
            else
            begin : g_body
                assign prev_gt    = cell_gt[gi-1];
                assign prev_value = cell_value[gi-1];
                assign prev_occ   = cell_occ[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                // the top cell empties as the set shifts out
                assign next_value = cell_value[gi];
                assign next_occ   = 1'b0;
            end
            else
            begin : g_mid
                assign next_value = cell_value[gi+1];
                assign next_occ   = cell_occ[gi+1];
            end

            lsd_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (item.value),
                .prev_gt    (prev_gt),
                .prev_value (prev_value),
                .prev_occ   (prev_occ),
                .next_value (next_value),
                .next_occ   (next_occ),
                .gt         (cell_gt[gi]),
                .value      (cell_value[gi]),
                .occ        (cell_occ[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next        = state_reg;
        overflow_next     = overflow_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    // an item that finds the set full is discarded but may still close it
                    if (full)
                        overflow_next = 1'b1;
                    if (item.last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // cell zero always holds the smallest value still in the chain
                result_valid_next        = 1'b1;
                result_next.sorted_value = cell_value[0];
                result_next.last_out     = !cell_occ[1];
                result_next.dropped      = overflow_reg;
                if (!cell_occ[1])
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            overflow_reg     <= overflow_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the chain is never drained empty
    a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> cell_occ[0])
        else $error("draining with an empty chain");

    // occupied cells always form an unbroken run from cell zero
    a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_occ + {{(MAX_ITEMS-1){1'b0}}, 1'b1}) & cell_occ) == '0)
        else $error("gap in cell occupancy");

    // a result that is not the final one is followed by more drain cycles
    a_more_to_come: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_out |-> busy)
        else $error("drain stopped before the final result");

    // every result comes from a drain cycle
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a drain cycle");

    // the cell chain stays in ascending order between its two lowest cells
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_occ[1] |-> cell_value[0] <= cell_value[1])
        else $error("cell chain out of order");

endmodule

// ===== rtl/lsd_cell.sv =====
// one cell of the sorting chain: holds one value and its occupancy bit
module lsd_cell
    import lsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsd_cell_ctrl_t         ctrl,
    input  logic [LSD_VALUE_W-1:0] new_value,
    input  logic                   prev_gt,
    input  logic [LSD_VALUE_W-1:0] prev_value,
    input  logic                   prev_occ,
    input  logic [LSD_VALUE_W-1:0] next_value,
    input  logic                   next_occ,
    output logic                   gt,
    output logic [LSD_VALUE_W-1:0] value,
    output logic                   occ
);

    logic [LSD_VALUE_W-1:0] value_reg;
    logic [LSD_VALUE_W-1:0] value_next;
    logic                   occ_reg;
    logic                   occ_next;

    // an empty cell counts as holding something larger than any value
    assign gt    = !occ_reg || (value_reg > new_value);
    assign value = value_reg;
    assign occ   = occ_reg;

    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (ctrl.shift_out)
        begin
            value_next = next_value;
            occ_next   = next_occ;
        end
        else if (ctrl.insert && gt)
        begin
            // first larger cell takes the new value, the rest move up by one
            value_next = prev_gt ? prev_value : new_value;
            occ_next   = occ_reg | prev_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== sim/lsd_radix_sorter_core_test.sv =====
// self-checking testbench for the radix sorter core: random sets, own sort prediction
`timescale 1ns / 1ps

module lsd_radix_sorter_core_test;
    import lsd_pkg::*;

    // base ten digits, and ten passes cover every 31-bit value
    localparam int RADIX       = 10;
    localparam int DIGIT_LIMIT = 10;
    // run is cut off here whatever happens
    localparam int CYCLE_LIMIT = 400000;
    // quiet tail at the end: a full drain of the largest set and some margin
    localparam int TAIL_CYCLES = 2 * LSD_MAX_ITEMS + 16;

    typedef logic [LSD_VALUE_W-1:0] word_t;

    // one queued item; hold_first makes the sender wait for an empty block
    typedef struct {
        lsd_in_t pkt;
        bit      hold_first;
    } feed_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    lsd_in_t  item  = '0;
    logic     busy;
    logic     result_valid;
    lsd_out_t result;

    lsd_radix_sorter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    feed_t    feed_q[$];
    lsd_out_t sorted_due[$];

    // copy of the set being collected
    word_t set_vals [LSD_MAX_ITEMS];
    int    set_count = 0;
    word_t set_max   = '0;
    bit    set_lost  = 1'b0;

    int errors    = 0;
    int cycles    = 0;
    int fed_items = 0;

    // sender pacing
    int burst_left = 1;
    int gap_left   = 0;
    bit took;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // stable counting sort on every decimal digit, lowest first, while the
    // maximum still has digits at this weight; then queue the sorted set
    task automatic sort_and_queue();
        word_t       spare [LSD_MAX_ITEMS];
        int          tally [RADIX];
        logic [31:0] weight;
        int          pass_no;
        int          i;
        int          d;
        lsd_out_t    r;
        weight = 32'd1;
        for (pass_no = 0; pass_no < DIGIT_LIMIT && ({1'b0, set_max} / weight) != 0;
             pass_no++)
        begin
            for (d = 0; d < RADIX; d++)
                tally[d] = 0;
            for (i = 0; i < set_count; i++)
            begin
                d = int'(({1'b0, set_vals[i]} / weight) % RADIX);
                tally[d]++;
            end
            for (d = 1; d < RADIX; d++)
                tally[d] += tally[d-1];
            // place from the back so equal digits keep their order
            for (i = set_count - 1; i >= 0; i--)
            begin
                d = int'(({1'b0, set_vals[i]} / weight) % RADIX);
                tally[d]--;
                spare[tally[d]] = set_vals[i];
            end
            for (i = 0; i < set_count; i++)
                set_vals[i] = spare[i];
            if (pass_no + 1 < DIGIT_LIMIT)
                weight = weight * RADIX;
        end
        for (i = 0; i < set_count; i++)
        begin
            r.sorted_value = set_vals[i];
            r.last_out     = (i == set_count - 1);
            r.dropped      = set_lost;
            sorted_due.push_back(r);
        end
        set_count = 0;
        set_max   = '0;
        set_lost  = 1'b0;
    endtask

    // one accepted transfer: store it, or mark the set as having lost items
    task automatic absorb_item(input lsd_in_t it);
        if (set_count < LSD_MAX_ITEMS)
        begin
            set_vals[set_count] = it.value;
            set_count++;
            if (it.value > set_max)
                set_max = it.value;
        end
        else
        begin
            set_lost = 1'b1;
        end
        if (it.last)
            sort_and_queue();
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    // magnitudes spread over one digit up to the full 31 bits
    function automatic word_t pick_value();
        case ($urandom_range(0, 5))
            0:       return word_t'($urandom_range(0, 9));
            1:       return word_t'($urandom_range(0, 999));
            2:       return word_t'($urandom % 1000000);
            3:       return word_t'($urandom % 1000000000);
            4:       return word_t'($urandom);
            default: return word_t'(32'h7FFF_FFFF - $urandom_range(0, 20));
        endcase
    endfunction

    task automatic queue_item(input word_t v, input bit is_last, input bit hold);
        feed_t f;
        f.pkt.value  = v;
        f.pkt.last   = is_last;
        f.hold_first = hold;
        feed_q.push_back(f);
        fed_items++;
    endtask

    task automatic queue_random_set(input int n, input bit hold);
        int i;
        for (i = 0; i < n; i++)
            queue_item(pick_value(), i == n - 1, hold && i == 0);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transfers with random gaps; an item once shown
    // stays on the port until the block takes it
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                absorb_item(item);
                void'(feed_q.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    // a quarter of bursts run straight on with no gap
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    burst_left = $urandom_range(1, 20);
                end
            end
            if (start && !took)
            begin
                // transfer still pending, keep start and item as they are
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (feed_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (feed_q[0].hold_first && sorted_due.size() != 0)
            begin
                // wait for the previous sets to drain completely
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                item  <= feed_q[0].pkt;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed result is checked against the oldest one due
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (sorted_due.size() == 0)
            begin
                $error("result with none due: sorted_value %0d last_out %0b dropped %0b",
                       result.sorted_value, result.last_out, result.dropped);
                errors++;
            end
            else
            begin
                if (result.sorted_value !== sorted_due[0].sorted_value)
                begin
                    $error("sorted_value: expected %0d, got %0d",
                           sorted_due[0].sorted_value, result.sorted_value);
                    errors++;
                end
                if (result.last_out !== sorted_due[0].last_out)
                begin
                    $error("last_out: expected %0b, got %0b",
                           sorted_due[0].last_out, result.last_out);
                    errors++;
                end
                if (result.dropped !== sorted_due[0].dropped)
                begin
                    $error("dropped: expected %0b, got %0b",
                           sorted_due[0].dropped, result.dropped);
                    errors++;
                end
                void'(sorted_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("lsd_radix_sorter_core_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: fill the queue, reset, then wait for the drain and a tail
    // ------------------------------------------------------------------
    initial
    begin
        // a single zero: maximum zero, so no digit pass at all
        queue_item(31'd0, 1'b1, 1'b0);
        // a single full-scale value
        queue_item(31'h7FFF_FFFF, 1'b1, 1'b0);
        // all zeros in a set of two
        queue_item(31'd0, 1'b0, 1'b0);
        queue_item(31'd0, 1'b1, 1'b0);
        // one digit only, reversed order
        queue_item(31'd3, 1'b0, 1'b0);
        queue_item(31'd2, 1'b0, 1'b0);
        queue_item(31'd1, 1'b1, 1'b0);
        // ten-digit maximum: the pass count reaches its cap
        queue_item(31'd9, 1'b0, 1'b0);
        queue_item(31'd0, 1'b0, 1'b0);
        queue_item(31'h7FFF_FFFF, 1'b0, 1'b0);
        queue_item(31'd10, 1'b0, 1'b0);
        queue_item(31'd1, 1'b0, 1'b0);
        queue_item(31'd100, 1'b0, 1'b0);
        queue_item(31'd99, 1'b0, 1'b0);
        queue_item(31'd1000000000, 1'b0, 1'b0);
        queue_item(31'd5, 1'b0, 1'b0);
        queue_item(31'd5, 1'b1, 1'b0);
        // near the top with equal digits in the low places
        queue_item(31'd1000000000, 1'b0, 1'b1);
        queue_item(31'd999999999, 1'b0, 1'b0);
        queue_item(31'h7FFF_FFFF, 1'b0, 1'b0);
        queue_item(31'd0, 1'b1, 1'b0);

        // a set that fills the store exactly
        queue_random_set(LSD_MAX_ITEMS, 1'b1);
        // set full and the closing item itself is discarded
        queue_random_set(LSD_MAX_ITEMS + 1, 1'b0);
        // set full with several discarded items before the close
        queue_random_set(LSD_MAX_ITEMS + 6, 1'b1);

        // mostly small sets, now and then a large one, some after a full drain
        while (fed_items < 330)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_random_set($urandom_range(LSD_MAX_ITEMS - 4, LSD_MAX_ITEMS + 3),
                                 $urandom_range(0, 1) == 1);
            else
                queue_random_set($urandom_range(1, 8), $urandom_range(0, 5) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || sorted_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("lsd_radix_sorter_core_test: clean");
        else
            $display("lsd_radix_sorter_core_test: errors");
        $finish;
    end

endmodule
